// File: rtl/core/ccsg_pkg.sv
// shared types and constants for the contour quad segment generator
`timescale 1ns / 1ps
`default_nettype none
package ccsg_pkg;

   localparam int VAL_W = 32;   // width of heights, coordinates and output words
   localparam int LEV_W = 36;   // internal width of a level in Q.F form
   localparam int MAG_W = 36;   // multiplicand / dividend magnitude width
   localparam int NUM_W = 33;   // multiplier and divisor width

   localparam logic [1:0] KIND_SEGMENT = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;
   localparam logic [1:0] KIND_EXCEED  = 2'd3;

   localparam logic CSR_LEVEL_INTERVAL = 1'b0;
   localparam logic CSR_RASTER_MINIMUM = 1'b1;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
   } corner_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] corner_a_value;
      logic signed [VAL_W-1:0] corner_a_x;
      logic signed [VAL_W-1:0] corner_a_y;
      logic signed [VAL_W-1:0] corner_g_value;
      logic signed [VAL_W-1:0] corner_g_x;
      logic signed [VAL_W-1:0] corner_g_y;
      logic signed [VAL_W-1:0] corner_i_value;
      logic signed [VAL_W-1:0] corner_i_x;
      logic signed [VAL_W-1:0] corner_i_y;
      logic signed [VAL_W-1:0] corner_c_value;
      logic signed [VAL_W-1:0] corner_c_x;
      logic signed [VAL_W-1:0] corner_c_y;
   } req_type;

   typedef struct packed {
      logic [1:0]              item_kind;
      logic signed [VAL_W-1:0] contour_level;
      logic signed [VAL_W-1:0] slot_index;
      logic signed [VAL_W-1:0] start_x;
      logic signed [VAL_W-1:0] start_y;
      logic signed [VAL_W-1:0] end_x;
      logic signed [VAL_W-1:0] end_y;
      logic                    left_high;
      logic                    last_of_quad;
   } rsp_type;

   // one classified quad handed from front to back
   typedef struct packed {
      corner_type [3:0]        corner;     // 0 a, 1 g, 2 i, 3 c
      logic signed [VAL_W-1:0] max_value;
      logic signed [LEV_W-1:0] level0;
      logic [VAL_W-1:0]        slot0;
   } job_type;

endpackage
`default_nettype wire

// File: rtl/core/ccsg_muldiv.sv
// bit-serial unit computing floor(mag*num/den) and its remainder, num <= den
`timescale 1ns / 1ps
`default_nettype none
module ccsg_muldiv import ccsg_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MAG_W-1:0] mag,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [NUM_W-1:0] den,
   output logic                  done,
   output logic [MAG_W-1:0]      quo,
   output logic [NUM_W-1:0]      rem
);
   localparam int CNT_W = $clog2(MAG_W + 1);
   localparam int ACC_W = NUM_W + 2;

   logic [MAG_W-1:0] mag_ff, mag_in, quo_ff, quo_in;
   logic [NUM_W-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [ACC_W-1:0] acc, den1, den2, red;
   logic [1:0]       inc;

   always_comb begin
      acc  = {1'b0, rem_ff, 1'b0} + (mag_ff[MAG_W-1] ? ACC_W'(num_ff) : '0);
      den1 = ACC_W'(den_ff);
      den2 = {1'b0, den_ff, 1'b0};
      if (acc >= den2) begin
         red = acc - den2;
         inc = 2'd2;
      end else if (acc >= den1) begin
         red = acc - den1;
         inc = 2'd1;
      end else begin
         red = acc;
         inc = 2'd0;
      end
      mag_in  = mag_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = mag;
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = mag_ff << 1;
         quo_in = (quo_ff << 1) + MAG_W'(inc);
         rem_in = NUM_W'(red);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

// File: rtl/core/ccsg_front.sv
// front part: takes a quad, finds its height range, first level and first slot
`timescale 1ns / 1ps
`default_nettype none
module ccsg_front import ccsg_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_item,
   input  wire logic [NUM_W-1:0]        level_step,
   input  wire logic signed [VAL_W-1:0] raster_minimum,
   input  wire logic                    job_full,
   output logic                         job_push,
   output job_type                      job_item
);
   typedef enum logic [7:0] {
      F_IDLE   = 8'b0000_0001,
      F_RANGE  = 8'b0000_0010,
      F_DIV1S  = 8'b0000_0100,
      F_DIV1W  = 8'b0000_1000,
      F_DIV2S  = 8'b0001_0000,
      F_DIV2W  = 8'b0010_0000,
      F_PUSH   = 8'b0100_0000,
      F_SPARE  = 8'b1000_0000
   } fstate_type;

   fstate_type              state_ff, state_in;
   job_type                 job_ff, job_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [LEV_W-1:0] dvd_ff, dvd_in;
   logic signed [VAL_W-1:0] mn, mx;
   logic                    div_start, div_done;
   logic [MAG_W-1:0]        div_mag, div_quo;
   logic [NUM_W-1:0]        div_rem, rem_floor;
   logic [LEV_W-1:0]        quo_floor;
   logic                    neg;

   ccsg_muldiv u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .mag (div_mag), .num (NUM_W'(1)), .den (level_step),
      .done (div_done), .quo (div_quo), .rem (div_rem)
   );

   always_comb begin
      mn = job_ff.corner[0].value;
      mx = job_ff.corner[0].value;
      for (int j = 1; j < 4; j++) begin
         if (job_ff.corner[j].value < mn) mn = job_ff.corner[j].value;
         if (job_ff.corner[j].value > mx) mx = job_ff.corner[j].value;
      end
      // floor division from magnitude quotient
      neg       = dvd_ff[LEV_W-1];
      quo_floor = neg ? (-LEV_W'(div_quo) - ((div_rem != '0) ? LEV_W'(1) : '0))
                      : LEV_W'(div_quo);
      rem_floor = (neg && div_rem != '0) ? level_step - div_rem : div_rem;
      div_mag   = dvd_ff[LEV_W-1] ? MAG_W'(-dvd_ff) : MAG_W'(dvd_ff);
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      min_in    = min_ff;
      dvd_in    = dvd_ff;
      div_start = 1'b0;
      job_push  = 1'b0;
      req_ready = (state_ff == F_IDLE);
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               job_in.corner[0] = '{req_item.corner_a_value, req_item.corner_a_x,
                                    req_item.corner_a_y};
               job_in.corner[1] = '{req_item.corner_g_value, req_item.corner_g_x,
                                    req_item.corner_g_y};
               job_in.corner[2] = '{req_item.corner_i_value, req_item.corner_i_x,
                                    req_item.corner_i_y};
               job_in.corner[3] = '{req_item.corner_c_value, req_item.corner_c_x,
                                    req_item.corner_c_y};
               state_in = F_RANGE;
            end
         end
         F_RANGE: begin
            min_in           = mn;
            job_in.max_value = mx;
            dvd_in           = LEV_W'(mn);
            state_in         = F_DIV1S;
         end
         F_DIV1S: begin
            div_start = 1'b1;
            state_in  = F_DIV1W;
         end
         F_DIV1W: begin
            if (div_done) begin
               // first level lies at or just below the minimum
               job_in.level0 = LEV_W'(min_ff) - LEV_W'(rem_floor);
               dvd_in   = LEV_W'(min_ff) - LEV_W'(rem_floor) - LEV_W'(raster_minimum);
               state_in = F_DIV2S;
            end
         end
         F_DIV2S: begin
            div_start = 1'b1;
            state_in  = F_DIV2W;
         end
         F_DIV2W: begin
            if (div_done) begin
               job_in.slot0 = quo_floor[VAL_W-1:0];
               state_in     = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      min_ff <= min_in;
      dvd_ff <= dvd_in;
      if (reset) state_ff <= F_IDLE;
      else       state_ff <= state_in;
   end

   assign job_item = job_ff;
endmodule
`default_nettype wire

// File: rtl/core/ccsg_fifo.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module ccsg_fifo import ccsg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_item,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head
);
   job_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rd_ff];
endmodule
`default_nettype wire

// File: rtl/core/ccsg_back.sv
// back part: walks levels and edges, interpolates crossings, emits items
`timescale 1ns / 1ps
`default_nettype none
module ccsg_back import ccsg_pkg::*; #(
   parameter int MAX_LEVELS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_empty,
   input  wire job_type          job_head,
   output logic                  job_pop,
   input  wire logic [NUM_W-1:0] level_step,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item
);
   localparam int DONE_W = $clog2(MAX_LEVELS + 1);

   typedef enum logic [10:0] {
      B_IDLE   = 11'b000_0000_0001,
      B_LEVEL  = 11'b000_0000_0010,
      B_EDGE   = 11'b000_0000_0100,
      B_XSTART = 11'b000_0000_1000,
      B_XWAIT  = 11'b000_0001_0000,
      B_YSTART = 11'b000_0010_0000,
      B_YWAIT  = 11'b000_0100_0000,
      B_NEXT   = 11'b000_1000_0000,
      B_PAIR   = 11'b001_0000_0000,
      B_EMIT   = 11'b010_0000_0000,
      B_CLOSE  = 11'b100_0000_0000
   } bstate_type;

   bstate_type              state_ff, state_in;
   job_type                 job_ff, job_in;
   corner_type [3:0]        rot_ff, rot_in;
   corner_type              base_ff, base_in, other_ff, other_in;
   logic [NUM_W-1:0]        num_ff, num_in, den_ff, den_in;
   logic signed [LEV_W-1:0] lv_ff, lv_in;
   logic [VAL_W-1:0]        slot_ff, slot_in;
   logic [DONE_W-1:0]       done_ff, done_in;
   logic [1:0]              eidx_ff, eidx_in, kind_ff, kind_in;
   logic [2:0]              n_ff, n_in, n1_ff, n1_in, n2_ff, n2_in, n3_ff, n3_in;
   logic signed [VAL_W-1:0] px_ff [4];
   logic signed [VAL_W-1:0] py_ff [4];
   logic                    neg_ff, neg_in;
   logic                    seg1_ff, seg1_in, seg2_ff, seg2_in, err_ff, err_in;
   logic                    lh1_ff, lh1_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    div_start, div_done, can_load, pt_write;
   logic [MAG_W-1:0]        div_mag, div_quo;
   logic [NUM_W-1:0]        div_rem;
   logic signed [LEV_W-1:0] v1, v2, v3, va, vg, vi, vc;
   logic signed [VAL_W:0]   diff;
   logic signed [VAL_W-1:0] bcoord, ocoord, pt;
   logic [MAG_W-1:0]        qr;
   logic                    is_y, up, down, flat, a_on, g_on, c_on;
   logic signed [LEV_W:0]   prev_lv;

   ccsg_muldiv u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .mag (div_mag), .num (num_ff), .den (den_ff),
      .done (div_done), .quo (div_quo), .rem (div_rem)
   );

   always_comb begin
      v1   = LEV_W'(rot_ff[0].value);
      v2   = LEV_W'(rot_ff[1].value);
      v3   = LEV_W'(rot_ff[2].value);
      va   = LEV_W'(job_ff.corner[0].value);
      vg   = LEV_W'(job_ff.corner[1].value);
      vi   = LEV_W'(job_ff.corner[2].value);
      vc   = LEV_W'(job_ff.corner[3].value);
      up   = (v1 < lv_ff) && (v2 >= lv_ff);
      down = (v1 > lv_ff) && (v2 <= lv_ff);
      flat = (v1 == lv_ff) && (v2 == lv_ff) && (v3 != lv_ff);
      a_on = (va == lv_ff);
      g_on = (vg == lv_ff);
      c_on = (vc == lv_ff);
      is_y    = (state_ff == B_YSTART) || (state_ff == B_YWAIT);
      bcoord  = is_y ? base_ff.y : base_ff.x;
      ocoord  = is_y ? other_ff.y : other_ff.x;
      diff    = (VAL_W+1)'(ocoord) - (VAL_W+1)'(bcoord);
      div_mag = diff[VAL_W] ? MAG_W'(-diff) : MAG_W'(diff);
      // offset rounded to nearest, ties away from the base corner
      qr = div_quo + (({div_rem, 1'b0} >= {1'b0, den_ff}) ? MAG_W'(1) : '0);
      pt = neg_ff ? bcoord - VAL_W'(qr) : bcoord + VAL_W'(qr);
      prev_lv  = (LEV_W+1)'(lv_ff) - (LEV_W+1)'(level_step);
      can_load = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rot_in       = rot_ff;
      base_in      = base_ff;
      other_in     = other_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      lv_in        = lv_ff;
      slot_in      = slot_ff;
      done_in      = done_ff;
      eidx_in      = eidx_ff;
      kind_in      = kind_ff;
      n_in         = n_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      n3_in        = n3_ff;
      neg_in       = neg_ff;
      seg1_in      = seg1_ff;
      seg2_in      = seg2_ff;
      err_in       = err_ff;
      lh1_in       = lh1_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      job_pop      = 1'b0;
      pt_write     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_head;
               lv_in    = job_head.level0;
               slot_in  = job_head.slot0;
               done_in  = '0;
               state_in = B_LEVEL;
            end
         end
         B_LEVEL: begin
            if (!(prev_lv < (LEV_W+1)'(job_ff.max_value))) begin
               kind_in  = KIND_DONE;
               state_in = B_CLOSE;
            end else if (done_ff == DONE_W'(MAX_LEVELS)) begin
               kind_in  = KIND_EXCEED;
               state_in = B_CLOSE;
            end else begin
               rot_in   = job_ff.corner;
               n_in     = '0;
               eidx_in  = '0;
               state_in = B_EDGE;
            end
         end
         B_EDGE: begin
            if (up) begin
               base_in  = rot_ff[0];
               other_in = rot_ff[1];
               num_in   = NUM_W'(lv_ff - v1);
               den_in   = NUM_W'(v2 - v1);
               state_in = B_XSTART;
            end else if (down) begin
               base_in  = rot_ff[1];
               other_in = rot_ff[0];
               num_in   = NUM_W'(lv_ff - v2);
               den_in   = NUM_W'(v1 - v2);
               state_in = B_XSTART;
            end else if (flat) begin
               // whole edge on the level: its far corner is the crossing
               base_in  = rot_ff[1];
               pt_write = 1'b1;
               n_in     = n_ff + 3'd1;
               state_in = B_NEXT;
            end else begin
               state_in = B_NEXT;
            end
         end
         B_XSTART: begin
            div_start = 1'b1;
            neg_in    = diff[VAL_W];
            state_in  = B_XWAIT;
         end
         B_XWAIT: begin
            if (div_done) state_in = B_YSTART;
         end
         B_YSTART: begin
            div_start = 1'b1;
            neg_in    = diff[VAL_W];
            state_in  = B_YWAIT;
         end
         B_YWAIT: begin
            if (div_done) begin
               n_in     = n_ff + 3'd1;
               state_in = B_NEXT;
            end
         end
         B_NEXT: begin
            case (eidx_ff)
               2'd0:    n1_in = n_ff;
               2'd1:    n2_in = n_ff;
               2'd2:    n3_in = n_ff;
               default: ;
            endcase
            for (int j = 0; j < 4; j++) rot_in[j] = rot_ff[(j + 1) % 4];
            eidx_in = eidx_ff + 2'd1;
            if (eidx_ff == 2'd3) state_in = B_PAIR;
            else                 state_in = B_EDGE;
         end
         B_PAIR: begin
            seg1_in = 1'b0;
            err_in  = 1'b0;
            lh1_in  = 1'b0;
            if (n_ff >= 3'd2) begin
               if (n1_ff == 3'd1 && n2_ff == 3'd2) begin
                  seg1_in = 1'b1;
                  lh1_in  = vc > vg;
               end else if (n1_ff == 3'd1 && n3_ff == 3'd2) begin
                  seg1_in = 1'b1;
                  lh1_in  = va > vi;
               end else if (n1_ff == 3'd1 && n_ff == 3'd2) begin
                  seg1_in = !(a_on && g_on);
                  lh1_in  = va > vi;
               end else if (n2_ff == 3'd1 && n3_ff == 3'd2) begin
                  seg1_in = 1'b1;
                  lh1_in  = va > vi;
               end else if (n2_ff == 3'd1 && n_ff == 3'd2) begin
                  seg1_in = 1'b1;
                  lh1_in  = vg > vc;
               end else if (n3_ff == 3'd1 && n_ff == 3'd2) begin
                  seg1_in = !(c_on && a_on);
                  lh1_in  = vg > vc;
               end else begin
                  err_in = 1'b1;
               end
            end
            seg2_in  = (n_ff == 3'd4) && !(c_on && a_on);
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (err_ff) begin
               kind_in  = KIND_PATTERN;
               state_in = B_CLOSE;
            end else if (seg1_ff || seg2_ff) begin
               if (can_load) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.item_kind     = KIND_SEGMENT;
                  rsp_in.contour_level = VAL_W'(lv_ff >>> FRAC_BITS);
                  rsp_in.slot_index    = slot_ff;
                  rsp_in.last_of_quad  = 1'b0;
                  if (seg1_ff) begin
                     rsp_in.start_x   = px_ff[0];
                     rsp_in.start_y   = py_ff[0];
                     rsp_in.end_x     = px_ff[1];
                     rsp_in.end_y     = py_ff[1];
                     rsp_in.left_high = lh1_ff;
                     seg1_in          = 1'b0;
                  end else begin
                     rsp_in.start_x   = px_ff[2];
                     rsp_in.start_y   = py_ff[2];
                     rsp_in.end_x     = px_ff[3];
                     rsp_in.end_y     = py_ff[3];
                     rsp_in.left_high = vi > vc;
                     seg2_in          = 1'b0;
                  end
               end
            end else begin
               lv_in    = lv_ff + LEV_W'(level_step);
               slot_in  = slot_ff + VAL_W'(1);
               done_in  = done_ff + DONE_W'(1);
               state_in = B_LEVEL;
            end
         end
         B_CLOSE: begin
            if (can_load) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.item_kind    = kind_ff;
               rsp_in.last_of_quad = 1'b1;
               state_in            = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      rot_ff   <= rot_in;
      base_ff  <= base_in;
      other_ff <= other_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      lv_ff    <= lv_in;
      slot_ff  <= slot_in;
      done_ff  <= done_in;
      eidx_ff  <= eidx_in;
      kind_ff  <= kind_in;
      n_ff     <= n_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      n3_ff    <= n3_in;
      neg_ff   <= neg_in;
      seg1_ff  <= seg1_in;
      seg2_ff  <= seg2_in;
      err_ff   <= err_in;
      lh1_ff   <= lh1_in;
      rsp_ff   <= rsp_in;
      if (pt_write) begin
         px_ff[n_ff[1:0]] <= rot_ff[1].x;
         py_ff[n_ff[1:0]] <= rot_ff[1].y;
      end else if (state_ff == B_XWAIT && div_done) begin
         px_ff[n_ff[1:0]] <= pt;
      end else if (state_ff == B_YWAIT && div_done) begin
         py_ff[n_ff[1:0]] <= pt;
      end
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/core/contour_quad_segment_generator.sv
// top level of the contour quad segment generator
// usage:
//   req channel (req_valid / req_ready / req_item) takes one quad: four corners
//   a, g, i, c with a height and x, y each, all signed fixed point
//   rsp channel (rsp_valid / rsp_ready / rsp_item) returns the quad's segment
//   items, then exactly one closing item with last_of_quad set
//   csr port writes level_interval (index 0) and raster_minimum (index 1);
//   the user writes them only while the block is idle, which it does not enforce
// operation:
//   the front finds the first level and first slot of a quad on its serial
//   divider; the back interpolates the x and y of each crossing on its serial
//   multiply-divide unit, walking the quad's levels one after another
//   a two-entry queue lets the front classify the next quad meanwhile
// reset: synchronous, clears control state, registers go to interval 1,
//   raster minimum 0
// stall: a result waits in the output register; the back halts at the next one
`timescale 1ns / 1ps
`default_nettype none
module contour_quad_segment_generator import ccsg_pkg::*; #(
   parameter int MAX_LEVELS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [VAL_W-1:0] csr_wdata
);
   // configuration registers
   logic [15:0]             interval_ff;
   logic signed [VAL_W-1:0] rmin_ff;
   logic [NUM_W-1:0]        level_step;

   // queue between front and back
   logic    job_push, job_pop, job_full, job_empty;
   job_type job_item, job_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd1;
         rmin_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LEVEL_INTERVAL: interval_ff <= csr_wdata[15:0];
            CSR_RASTER_MINIMUM: rmin_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero interval counts as one; step is the interval in fixed point
   assign level_step = NUM_W'((interval_ff == 16'd0) ? 16'd1 : interval_ff) << FRAC_BITS;

   ccsg_front u_front (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready), .req_item (req_item),
      .level_step (level_step), .raster_minimum (rmin_ff),
      .job_full (job_full), .job_push (job_push), .job_item (job_item)
   );

   ccsg_fifo u_fifo (
      .clock (clock), .reset (reset),
      .push (job_push), .push_item (job_item), .full (job_full),
      .pop (job_pop), .empty (job_empty), .head (job_head)
   );

   ccsg_back #(.MAX_LEVELS (MAX_LEVELS), .FRAC_BITS (FRAC_BITS)) u_back (
      .clock (clock), .reset (reset),
      .job_empty (job_empty), .job_head (job_head), .job_pop (job_pop),
      .level_step (level_step),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready), .rsp_item (rsp_item)
   );

   // queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty) else $error("job queue underflow");
   // closing items and only they carry last_of_quad
   a_close_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last_of_quad == (rsp_item.item_kind != KIND_SEGMENT)))
      else $error("closing flag and item kind disagree");
   // a closing item carries a zero level, slot, start_x, end_y and left_high
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_of_quad) |->
         (rsp_item.contour_level == 0 && rsp_item.slot_index == 0 &&
          rsp_item.start_x == 0 && rsp_item.end_y == 0 && !rsp_item.left_high))
      else $error("closing item payload not zero");
endmodule
`default_nettype wire

// File: tb/sv/contour_quad_segment_generator_test.sv
// testbench for the contour quad segment generator: directed table, random quads, scoreboard
`timescale 1ns / 1ps
module contour_quad_segment_generator_test;
   import ccsg_pkg::*;

   localparam int MAX_LEVELS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int N_RANDOM   = 15;  // random quads per configuration phase

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_item;
   logic             csr_write = 1'b0;
   logic             csr_index = CSR_LEVEL_INTERVAL;
   logic [VAL_W-1:0] csr_wdata = '0;

   contour_quad_segment_generator #(
      .MAX_LEVELS(MAX_LEVELS),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // our own copy of the two registers, tracked on every write
   logic [15:0]      model_interval = 16'd1;
   logic [VAL_W-1:0] model_minimum = '0;

   rsp_type segments_due[$];   // expected items in arrival order
   bit      failed = 1'b0;

   // idle percentages for each side, and the long receiver hold-off
   int snd_idle_pct = 25;
   int rcv_idle_pct = 66;
   bit hold_toggle = 1'b0;
   int hold_cycles = 0;

   // ---------------------------------------------------------------- predictor

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   // base + (other-base)*num/den, offset rounded to nearest, ties away from base
   function automatic longint lerp_point(longint base, longint other,
                                         longint unsigned num, longint unsigned den);
      longint          diff;
      longint unsigned mag, prod, q, r;
      diff = other - base;
      mag  = diff < 0 ? longint'(-diff) : longint'(diff);
      prod = mag * num;
      q    = prod / den;
      r    = prod % den;
      if (r >= den - r) q++;
      return diff < 0 ? base - longint'(q) : base + longint'(q);
   endfunction

   // one edge v1 -> v2 (v3 is the corner after v2), adds at most one crossing
   function automatic void edge_crossing(inout longint px[4], inout longint py[4],
                                         inout int n, input longint v1, x1, y1,
                                         v2, x2, y2, v3, lv);
      int k;
      k = n & 3;
      if (v1 < lv && v2 >= lv) begin
         px[k] = lerp_point(x1, x2, lv - v1, v2 - v1);
         py[k] = lerp_point(y1, y2, lv - v1, v2 - v1);
         n++;
      end else if (v1 > lv && v2 <= lv) begin
         px[k] = lerp_point(x2, x1, lv - v2, v1 - v2);
         py[k] = lerp_point(y2, y1, lv - v2, v1 - v2);
         n++;
      end else if (v1 == lv && v2 == lv && v3 != lv) begin
         px[k] = x2;
         py[k] = y2;
         n++;
      end
   endfunction

   function automatic rsp_type make_segment(longint lvl, slot, sx, sy, ex, ey, bit lh);
      rsp_type r;
      r.item_kind     = KIND_SEGMENT;
      r.contour_level = lvl[31:0];
      r.slot_index    = slot[31:0];
      r.start_x       = sx[31:0];
      r.start_y       = sy[31:0];
      r.end_x         = ex[31:0];
      r.end_y         = ey[31:0];
      r.left_high     = lh;
      r.last_of_quad  = 1'b0;
      return r;
   endfunction

   function automatic rsp_type closing_item(logic [1:0] kind);
      rsp_type r;
      r = '0;
      r.item_kind    = kind;
      r.last_of_quad = 1'b1;
      return r;
   endfunction

   // works out every item a quad causes and queues them
   function automatic void predict_quad(req_type q);
      longint a, ax, ay, g, gx, gy, i, ix, iy, c, cx, cy;
      longint ivl, step, mn, mx, k, ks, ke, lv, lvl, slot, rmin;
      longint px[4], py[4];
      int n, n1, n2, n3, levels_done;
      logic [1:0] close_kind;
      a = q.corner_a_value; ax = q.corner_a_x; ay = q.corner_a_y;
      g = q.corner_g_value; gx = q.corner_g_x; gy = q.corner_g_y;
      i = q.corner_i_value; ix = q.corner_i_x; iy = q.corner_i_y;
      c = q.corner_c_value; cx = q.corner_c_x; cy = q.corner_c_y;
      rmin = longint'($signed(model_minimum));
      ivl  = (model_interval == 0) ? 1 : longint'(model_interval);
      step = ivl << FRAC_BITS;
      mn = a; mx = a;
      if (g < mn) mn = g;
      if (i < mn) mn = i;
      if (c < mn) mn = c;
      if (g > mx) mx = g;
      if (i > mx) mx = i;
      if (c > mx) mx = c;
      ks = floor_quot(mn, step);
      ke = -floor_quot(-mx, step);
      levels_done = 0;
      close_kind = KIND_DONE;
      for (k = ks; k <= ke; k++) begin
         lv   = k * step;
         lvl  = k * ivl;
         slot = floor_quot(lv - rmin, step);
         if (levels_done == MAX_LEVELS) begin
            close_kind = KIND_EXCEED;
            break;
         end
         levels_done++;
         n = 0;
         edge_crossing(px, py, n, a, ax, ay, g, gx, gy, i, lv);
         n1 = n;
         edge_crossing(px, py, n, g, gx, gy, i, ix, iy, c, lv);
         n2 = n;
         edge_crossing(px, py, n, i, ix, iy, c, cx, cy, a, lv);
         n3 = n;
         edge_crossing(px, py, n, c, cx, cy, a, ax, ay, g, lv);
         if (n >= 2) begin
            if (n1 == 1 && n2 == 2)
               segments_due.push_back(make_segment(lvl, slot, px[0], py[0], px[1], py[1], c > g));
            else if (n1 == 1 && n3 == 2)
               segments_due.push_back(make_segment(lvl, slot, px[0], py[0], px[1], py[1], a > i));
            else if (n1 == 1 && n == 2) begin
               // flat first edge: its pair gives no segment
               if (!(a == lv && g == lv))
                  segments_due.push_back(make_segment(lvl, slot, px[0], py[0],
                                                      px[1], py[1], a > i));
            end else if (n2 == 1 && n3 == 2)
               segments_due.push_back(make_segment(lvl, slot, px[0], py[0], px[1], py[1], a > i));
            else if (n2 == 1 && n == 2)
               segments_due.push_back(make_segment(lvl, slot, px[0], py[0], px[1], py[1], g > c));
            else if (n3 == 1 && n == 2) begin
               // flat edge from c to a likewise
               if (!(c == lv && a == lv))
                  segments_due.push_back(make_segment(lvl, slot, px[0], py[0],
                                                      px[1], py[1], g > c));
            end else begin
               close_kind = KIND_PATTERN;
               break;
            end
         end
         // saddle: second segment unless c and a both sit on the level
         if (n == 4 && !(c == lv && a == lv))
            segments_due.push_back(make_segment(lvl, slot, px[2], py[2], px[3], py[3], i > c));
      end
      segments_due.push_back(closing_item(close_kind));
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, longint unsigned want, got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (segments_due.size() == 0) begin
            $error("item_kind: expected nothing, actual 0x%0h", rsp_item.item_kind);
            failed = 1'b1;
         end else begin
            want = segments_due.pop_front();
            check_field("item_kind", want.item_kind, rsp_item.item_kind);
            check_field("contour_level", want.contour_level, rsp_item.contour_level);
            check_field("slot_index", want.slot_index, rsp_item.slot_index);
            check_field("start_x", want.start_x, rsp_item.start_x);
            check_field("start_y", want.start_y, rsp_item.start_y);
            check_field("end_x", want.end_x, rsp_item.end_x);
            check_field("end_y", want.end_y, rsp_item.end_y);
            check_field("left_high", want.left_high, rsp_item.left_high);
            check_field("last_of_quad", want.last_of_quad, rsp_item.last_of_quad);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted here on request
   always @(negedge clock) begin
      bit seen_toggle;
      if (hold_toggle != seen_toggle) begin
         seen_toggle = hold_toggle;
         hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // offers one quad from a falling edge, returns at the falling edge after acceptance
   task automatic send_quad(req_type q);
      int gap;
      if ($urandom_range(99) < snd_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item  = q;
      do @(posedge clock); while (!req_ready);
      predict_quad(q);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_valid = 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_sender();
      while (segments_due.size() != 0) @(negedge clock);
   endtask

   task automatic csr_set(logic idx, logic [VAL_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      if (idx == CSR_LEVEL_INTERVAL) model_interval = data[15:0];
      else model_minimum = data;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'h7fffffff - $urandom_range(255);
         2: return 32'h80000000 + $urandom_range(255);
         default: return $urandom_range(4095) - 2048;
      endcase
   endfunction

   // height near a level, sometimes exactly on it, clipped to 32 bits
   function automatic logic [31:0] pick_height(longint centre, longint step);
      longint h;
      if ($urandom_range(3) == 0) h = centre + step * ($urandom_range(4) - 2);
      else h = centre + $urandom_range(6 * 256) - 3 * 256 + ($urandom_range(7) - 3) * step;
      if (h > 64'sh7fffffff) h = 64'sh7fffffff;
      if (h < -64'sh80000000) h = -64'sh80000000;
      return h[31:0];
   endfunction

   function automatic req_type random_quad();
      req_type q;
      longint step, centre;
      if ($urandom_range(4) == 0) begin
         // raw bits everywhere, mostly running into the level cap
         for (int w = 0; w < 12; w++) q[w*32 +: 32] = $urandom;
         return q;
      end
      step   = ((model_interval == 0) ? 1 : longint'(model_interval)) << FRAC_BITS;
      centre = step * ($urandom_range(200) - 100);
      if ($urandom_range(9) == 0) centre = longint'($signed(32'($urandom)));
      q.corner_a_value = pick_height(centre, step);
      q.corner_g_value = pick_height(centre, step);
      q.corner_i_value = pick_height(centre, step);
      q.corner_c_value = pick_height(centre, step);
      q.corner_a_x = pick_coord(); q.corner_a_y = pick_coord();
      q.corner_g_x = pick_coord(); q.corner_g_y = pick_coord();
      q.corner_i_x = pick_coord(); q.corner_i_y = pick_coord();
      q.corner_c_x = pick_coord(); q.corner_c_y = pick_coord();
      return q;
   endfunction

   // directed rows: heights a g i c, then one coordinate seed spread over the corners
   typedef struct {
      logic [31:0] ha, hg, hi, hc;
      logic [31:0] xy;      // coordinate seed, spread over the corners
      bit          typed;   // closing item alone, expected kind given below
      logic [1:0]  kind;
   } quad_row_type;

   quad_row_type quad_table[] = '{
      // flat quads: one closing item and nothing else
      '{32'h0,        32'h0,        32'h0,        32'h0,        32'h0,        1, KIND_DONE},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1, KIND_DONE},
      '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1, KIND_DONE},
      // simple single crossings, each corner high in turn
      '{32'h180,      32'h0,        32'h0,        32'h0,        32'h100,      0, KIND_DONE},
      '{32'h0,        32'h180,      32'h0,        32'h0,        32'h80000000, 0, KIND_DONE},
      '{32'h0,        32'h0,        32'h180,      32'h0,        32'h12345678, 0, KIND_DONE},
      '{32'h0,        32'h0,        32'h0,        32'h180,      32'hdeadbeef, 0, KIND_DONE},
      // horizontal split and saddles
      '{32'h200,      32'h200,      32'h0,        32'h0,        32'h400,      0, KIND_DONE},
      '{32'h200,      32'h0,        32'h200,      32'h0,        32'h1000,     0, KIND_DONE},
      '{32'h0,        32'h200,      32'h0,        32'h200,      32'hfffff000, 0, KIND_DONE},
      '{32'h100,      32'h0,        32'h100,      32'h0,        32'h800,      0, KIND_DONE},
      // edges lying on a level
      '{32'h100,      32'h100,      32'h0,        32'h0,        32'h300,      0, KIND_DONE},
      '{32'h100,      32'h0,        32'h0,        32'h100,      32'h300,      0, KIND_DONE},
      '{32'h100,      32'h100,      32'h100,      32'h0,        32'h300,      0, KIND_DONE},
      '{32'h0,        32'h100,      32'h100,      32'h100,      32'h300,      0, KIND_DONE},
      '{32'h100,      32'h0,        32'h100,      32'h100,      32'h300,      0, KIND_DONE},
      // odd crossing counts at some levels, which give no segment there
      '{32'h100,      32'h0,        32'h0,        32'h0,        32'h500,      0, KIND_DONE},
      '{32'h0,        32'h100,      32'h200,      32'h100,      32'h500,      0, KIND_DONE},
      // more levels than the block works
      '{32'h0,        32'h1400,     32'h2800,     32'h1400,     32'h40,       0, KIND_DONE},
      '{32'h80000000, 32'h7fffffff, 32'h0,        32'hffffffff, 32'h55555555, 0, KIND_DONE},
      // rounding ties on a non-unit fraction
      '{32'hffffff80, 32'h80,       32'h81,       32'hffffff7f, 32'haaaaaaaa, 0, KIND_DONE}
   };

   initial begin
      req_type     q;
      quad_row_type row;
      logic [31:0] s;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset configuration
      foreach (quad_table[r]) begin
         row = quad_table[r];
         s = row.xy;
         q.corner_a_value = row.ha; q.corner_a_x = s;        q.corner_a_y = ~s;
         q.corner_g_value = row.hg; q.corner_g_x = s + 256;  q.corner_g_y = s;
         q.corner_i_value = row.hi; q.corner_i_x = ~s;       q.corner_i_y = s - 256;
         q.corner_c_value = row.hc; q.corner_c_x = s ^ 32'h00ff00ff; q.corner_c_y = -s;
         if (row.typed) begin
            // flat quad: type in the closing item instead of predicting it
            req_valid = 1'b1;
            req_item  = q;
            do @(posedge clock); while (!req_ready);
            segments_due.push_back(closing_item(row.kind));
            @(negedge clock);
         end else begin
            send_quad(q);
         end
      end

      // configuration phases, idling modes rotate across them
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: begin csr_set(CSR_LEVEL_INTERVAL, 32'd0);
                     csr_set(CSR_RASTER_MINIMUM, $urandom); end
            1: begin csr_set(CSR_LEVEL_INTERVAL, 32'd65535);
                     csr_set(CSR_RASTER_MINIMUM, 32'h80000000); end
            2: begin csr_set(CSR_LEVEL_INTERVAL, 32'd3);
                     csr_set(CSR_RASTER_MINIMUM, 32'h7fffffff); end
            3: begin csr_set(CSR_LEVEL_INTERVAL, 32'd1);
                     csr_set(CSR_RASTER_MINIMUM, 32'h0); end
            4: begin csr_set(CSR_LEVEL_INTERVAL, 32'($urandom_range(65535)));
                     csr_set(CSR_RASTER_MINIMUM, $urandom); end
            default: begin csr_set(CSR_LEVEL_INTERVAL, 32'd2);
                     csr_set(CSR_RASTER_MINIMUM, 32'hffffff00); end
         endcase
         if (phase < 2) begin snd_idle_pct = 25; rcv_idle_pct = 66; end
         else if (phase < 4) begin snd_idle_pct = 66; rcv_idle_pct = 25; end
         else begin snd_idle_pct = 0; rcv_idle_pct = 0; end
         // long receiver hold-off while quads keep coming, so the input backs up
         if (phase == 4) hold_toggle = ~hold_toggle;
         for (int n = 0; n < N_RANDOM; n++) begin
            // once per run the sender waits for every result mid-phase
            if (phase == 5 && n == N_RANDOM / 2) wait_drained();
            send_quad(random_quad());
         end
      end

      wait_drained();
      repeat (200) @(negedge clock);
      if (!failed && segments_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // timeout
   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: contour_quad_segment_generator.f
rtl/core/ccsg_pkg.sv
rtl/core/ccsg_muldiv.sv
rtl/core/ccsg_front.sv
rtl/core/ccsg_fifo.sv
rtl/core/ccsg_back.sv
rtl/core/contour_quad_segment_generator.sv
tb/sv/contour_quad_segment_generator_test.sv
